/* rtl/dram_row_first_request_scheduler_assert.svh */
// Assertion macros shared by the scheduler modules.
`ifndef DRAM_ROW_FIRST_REQUEST_SCHEDULER_ASSERT_SVH
`define DRAM_ROW_FIRST_REQUEST_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DRFRS_ASSERT_IMPL(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DRFRS_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/drfrs_pkg.sv */
// Types, constants and codes shared by the row-first request scheduler.
package drfrs_pkg;

  localparam int QueueDepth  = 64;
  localparam int RowCount    = 1024;
  localparam int WordsPerRow = 256;
  localparam int RegCount    = 32;

  localparam int OpW     = 3;
  localparam int AddrW   = 20;
  localparam int RegW    = 5;
  localparam int DataW   = 32;
  localparam int StatusW = 3;
  localparam int KindW   = 2;
  localparam int LatW    = 12;
  localparam int CntW    = 32;
  localparam int DelayW  = 10;
  localparam int TagW    = 13;
  localparam int CfgIdxW = 1;

  localparam int RowW   = $clog2(RowCount);
  localparam int ColW   = $clog2(WordsPerRow);
  localparam int ARowW  = AddrW - ColW - 2;
  localparam int QIdxW  = $clog2(QueueDepth);
  localparam int QCntW  = $clog2(QueueDepth + 1);
  localparam int PRegW  = $clog2(RegCount);
  localparam int MemAW  = RowW + ColW;
  localparam int MemDepth = RowCount * WordsPerRow;

  typedef enum logic [OpW-1:0] {
    OP_LOAD     = 3'd0,
    OP_STORE    = 3'd1,
    OP_CANCEL   = 3'd2,
    OP_DISPATCH = 3'd3,
    OP_DRAIN    = 3'd4
  } op_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK       = 3'd0,
    ST_FWD      = 3'd1,
    ST_IDLE     = 3'd2,
    ST_FULL     = 3'd3,
    ST_MISALIGN = 3'd4,
    ST_RANGE    = 3'd5
  } status_t;

  typedef enum logic [KindW-1:0] {
    KIND_NONE  = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_STORE = 2'd2
  } kind_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROW_DELAY = 1'b0,
    CFG_COL_DELAY = 1'b1
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_PUSH,
    S_FINISH,
    S_SCAN_INIT,
    S_SCAN,
    S_SELECT,
    S_LOAD,
    S_CHECK,
    S_SERVE,
    S_FORM,
    S_SPUSH,
    S_DROP_RD,
    S_DROP_WR
  } state_t;

  typedef struct packed {
    logic             is_store;
    logic [RowW-1:0]  row;
    logic [ColW-1:0]  col;
    logic [PRegW-1:0] rg;
    logic [TagW-1:0]  tag;
    logic [DataW-1:0] value;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    status_t          status;
    kind_t            kind;
    logic [RegW-1:0]  rg;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
    logic [LatW-1:0]  lat;
    logic             sw;
    logic [CntW-1:0]  upd;
  } res_t;

  typedef struct packed {
    logic latch_in;
    logic exec;
    logic drain_latch;
    logic scan_start;
    logic scan_step;
    logic sel_read;
    logic sel_capture;
    logic check;
    logic serve;
    logic form;
    logic push;
    logic finish;
    logic drop_rd;
    logic drop_wr;
    logic drop_end;
    logic clear_step;
  } cmd_t;

  typedef struct packed {
    logic [OpW-1:0] op;
    logic clear_done;
    logic pend_valid;
    logic scan_done;
    logic found;
    logic stale;
    logic served;
    logic target;
    logic hold_valid;
    logic out_free;
    logic drop_more;
  } sts_t;

endpackage

/* rtl/drfrs_if.sv */
// Request and result channel interfaces of the row-first request scheduler.
interface drfrs_in_if import drfrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [OpW-1:0]          operation;
  logic [AddrW-1:0]        byte_address;
  logic [RegW-1:0]         reg_index;
  logic signed [DataW-1:0] store_value;

  modport source(output valid, output operation, output byte_address, output reg_index,
                 output store_value, input ready);
  modport sink(input valid, input operation, input byte_address, input reg_index,
               input store_value, output ready);
endinterface

interface drfrs_out_if import drfrs_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic [KindW-1:0]        done_kind;
  logic [RegW-1:0]         done_reg;
  logic [AddrW-1:0]        done_address;
  logic signed [DataW-1:0] data_value;
  logic [LatW-1:0]         latency_cycles;
  logic                    row_switched;
  logic [CntW-1:0]         buffer_update_count;
  logic                    last_of_run;

  modport source(output valid, output status, output done_kind, output done_reg,
                 output done_address, output data_value, output latency_cycles,
                 output row_switched, output buffer_update_count, output last_of_run,
                 input ready);
  modport sink(input valid, input status, input done_kind, input done_reg,
               input done_address, input data_value, input latency_cycles,
               input row_switched, input buffer_update_count, input last_of_run,
               output ready);
endinterface

/* rtl/dram_row_first_request_scheduler.sv */
// Top level of the row-first DRAM request scheduler.
// Requests enter on in_ch (valid/ready): enqueue load, enqueue store, cancel a
// register's pending load, dispatch, or drain a register. Each request gives one
// or more result beats on out_ch; the final beat of a request has last_of_run set.
// Configuration writes (cfg_we, cfg_index, cfg_data) set the row and column delays
// and are taken in any cycle.
// One request is processed at a time. A dispatch or drain scans the queue one
// entry per cycle through the queue memory port, then checks the pick for
// staleness and serves it if it is not stale; every dropped or served entry is
// then compacted out. A drain repeats this for each request it serves.
// After reset the word memory is cleared one word per cycle, all 262144 words,
// and in_ch.ready stays low during that pass.
// Results leave through an output register. When out_ch.ready is low, processing
// stops at the next result beat until that register is free.
module dram_row_first_request_scheduler import drfrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  drfrs_in_if.sink           in_ch,
  drfrs_out_if.source        out_ch,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DelayW-1:0]  cfg_data
);

  cmd_t cmd;
  sts_t sts;
  res_t res;
  logic in_ready;
  logic out_valid, out_last;

  drfrs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ready),
    .sts(sts), .cmd(cmd)
  );

  drfrs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_operation(in_ch.operation), .in_byte_address(in_ch.byte_address),
    .in_reg_index(in_ch.reg_index), .in_store_value(in_ch.store_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ch.ready), .out_res(res), .out_last(out_last)
  );

  assign in_ch.ready                = in_ready;
  assign out_ch.valid               = out_valid;
  assign out_ch.status              = res.status;
  assign out_ch.done_kind           = res.kind;
  assign out_ch.done_reg            = res.rg;
  assign out_ch.done_address        = res.addr;
  assign out_ch.data_value          = $signed(res.data);
  assign out_ch.latency_cycles      = res.lat;
  assign out_ch.row_switched        = res.sw;
  assign out_ch.buffer_update_count = res.upd;
  assign out_ch.last_of_run         = out_last;

endmodule

/* rtl/drfrs_ram.sv */
// Generic single-port RAM with registered read data.
module drfrs_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* rtl/drfrs_dp.sv */
// Datapath: request queue, word memory, pending loads, row state and result registers.
module drfrs_dp import drfrs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [OpW-1:0]     in_operation,
  input  logic [AddrW-1:0]   in_byte_address,
  input  logic [RegW-1:0]    in_reg_index,
  input  logic [DataW-1:0]   in_store_value,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [DelayW-1:0]  cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output res_t               out_res,
  output logic               out_last
);

  logic [DelayW-1:0] row_d_r, col_d_r;
  logic [OpW-1:0]    op_r;
  logic [AddrW-1:0]  addr_r;
  logic [PRegW-1:0]  reg_r;
  logic [DataW-1:0]  val_r;

  logic [QCntW-1:0]  count_r;
  logic [RegCount-1:0] pv_r;
  logic [TagW-1:0]   ptag_r [RegCount];
  logic [AddrW-1:0]  paddr_r [RegCount];
  logic [TagW-1:0]   seq_r;
  logic              ls_valid_r;
  logic [AddrW-1:0]  ls_addr_r;
  logic [DataW-1:0]  ls_val_r;
  logic              ov_r;
  logic [RowW-1:0]   orow_r;
  logic [CntW-1:0]   upd_r;
  logic [MemAW-1:0]  clr_r;

  logic [TagW-1:0]   dtag_r;
  logic [RowW-1:0]   drow_r;
  logic [ColW-1:0]   dcol_r;

  logic [QCntW-1:0]  scan_r;
  logic              rd_vld_r;
  logic [QIdxW-1:0]  rd_idx_r;
  logic              oh_f_r, m_f_r, d_f_r;
  logic [QIdxW-1:0]  oh_idx_r, m_idx_r, d_idx_r;
  logic [ColW-1:0]   oh_col_r, m_col_r;
  logic [RowW-1:0]   m_row_r;

  logic [QIdxW-1:0]  sel_idx_r;
  entry_t            sel_r;
  logic              served_r, target_r;
  logic [QIdxW-1:0]  comp_r;
  logic [LatW-1:0]   lat_r;
  logic              sw_r;

  res_t              res_r, hold_r, out_res_r;
  logic              hold_valid_r, out_valid_r, out_last_r;

  logic              q_we;
  logic [QIdxW-1:0]  q_addr;
  logic [EntryW-1:0] q_wdata, q_rdata;
  logic              m_we;
  logic [MemAW-1:0]  m_addr;
  logic [DataW-1:0]  m_wdata, m_rdata;

  logic [ARowW-1:0]  row_a;
  logic              range_bad, misal, fwd, full, is_mem_op, enq_ok;
  entry_t            new_e, scan_e;
  res_t              exec_res, served_res, idle_res;
  logic [PRegW-1:0]  pidx;
  logic              stale, is_target, out_free;
  logic              is_drain, found;
  logic [QIdxW-1:0]  chosen;
  logic              sw_c;
  logic [LatW-1:0]   lat_c;
  logic [CntW-1:0]   upd1, upd_nxt;
  logic              drop_more;

  drfrs_ram #(.Width(EntryW), .Depth(QueueDepth)) u_queue (
    .clk(clk), .we(q_we), .addr(q_addr), .wdata(q_wdata), .rdata(q_rdata)
  );

  drfrs_ram #(.Width(DataW), .Depth(MemDepth)) u_mem (
    .clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wdata), .rdata(m_rdata)
  );

  always_comb begin
    row_a     = addr_r[AddrW-1:ColW+2];
    is_mem_op = (op_r == OP_LOAD) || (op_r == OP_STORE);
    range_bad = {1'b0, row_a} >= (ARowW+1)'(RowCount);
    misal     = addr_r[1:0] != 2'b00;
    fwd       = (op_r == OP_LOAD) && ls_valid_r && (addr_r == ls_addr_r);
    full      = count_r >= QCntW'(QueueDepth);
    enq_ok    = cmd.exec && is_mem_op && !range_bad && !misal && !fwd && !full;

    new_e.is_store = op_r == OP_STORE;
    new_e.row      = RowW'(row_a);
    new_e.col      = addr_r[ColW+1:2];
    new_e.rg       = reg_r;
    new_e.tag      = seq_r;
    new_e.value    = val_r;

    exec_res        = '0;
    exec_res.status = ST_OK;
    exec_res.kind   = KIND_NONE;
    exec_res.upd    = upd_r;
    if (is_mem_op) begin
      exec_res.addr = addr_r;
      if (range_bad) begin
        exec_res.status = ST_RANGE;
      end else if (misal) begin
        exec_res.status = ST_MISALIGN;
      end else if (fwd) begin
        exec_res.status = ST_FWD;
        exec_res.rg     = RegW'(reg_r);
        exec_res.data   = ls_val_r;
      end else if (full) begin
        exec_res.status = ST_FULL;
      end
    end

    idle_res        = '0;
    idle_res.status = ST_IDLE;
    idle_res.kind   = KIND_NONE;
    idle_res.upd    = upd_r;

    served_res        = '0;
    served_res.status = ST_OK;
    served_res.kind   = sel_r.is_store ? KIND_STORE : KIND_LOAD;
    served_res.rg     = sel_r.is_store ? '0 : RegW'(sel_r.rg);
    served_res.addr   = AddrW'({sel_r.row, sel_r.col, 2'b00});
    served_res.data   = sel_r.is_store ? sel_r.value : m_rdata;
    served_res.lat    = lat_r;
    served_res.sw     = sw_r;
    served_res.upd    = upd_r;

    pidx      = cmd.check ? sel_r.rg : reg_r;
    stale     = !sel_r.is_store && (!pv_r[pidx] || (ptag_r[pidx] != sel_r.tag));
    is_target = !sel_r.is_store && (sel_r.rg == reg_r) && (sel_r.tag == dtag_r);

    scan_e   = entry_t'(q_rdata);
    is_drain = op_r == OP_DRAIN;
    found    = is_drain ? d_f_r : (oh_f_r || m_f_r);
    chosen   = is_drain ? d_idx_r : (oh_f_r ? oh_idx_r : m_idx_r);

    sw_c  = !ov_r || (orow_r != sel_r.row);
    lat_c = LatW'(col_d_r);
    if (sw_c) begin
      lat_c = lat_c + LatW'(row_d_r);
      if (ov_r) begin
        lat_c = lat_c + LatW'(row_d_r);
      end
    end
    upd1    = (sw_c && (upd_r != '1)) ? upd_r + 1'b1 : upd_r;
    upd_nxt = (sel_r.is_store && (upd1 != '1)) ? upd1 + 1'b1 : upd1;

    drop_more = (QCntW'(comp_r) + QCntW'(1)) < count_r;
    out_free  = !out_valid_r || out_ready;
  end

  always_comb begin
    q_we    = 1'b0;
    q_addr  = '0;
    q_wdata = new_e;
    if (enq_ok) begin
      q_we   = 1'b1;
      q_addr = count_r[QIdxW-1:0];
    end else if (cmd.scan_step) begin
      q_addr = scan_r[QIdxW-1:0];
    end else if (cmd.sel_read) begin
      q_addr = chosen;
    end else if (cmd.drop_rd) begin
      q_addr = comp_r + 1'b1;
    end else if (cmd.drop_wr) begin
      q_we    = 1'b1;
      q_addr  = comp_r;
      q_wdata = q_rdata;
    end

    m_we    = 1'b0;
    m_addr  = {sel_r.row, sel_r.col};
    m_wdata = sel_r.value;
    if (cmd.clear_step) begin
      m_we    = 1'b1;
      m_addr  = clr_r;
      m_wdata = '0;
    end else if (cmd.serve) begin
      m_we = sel_r.is_store;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_d_r      <= DelayW'(10);
      col_d_r      <= DelayW'(2);
      count_r      <= '0;
      pv_r         <= '0;
      seq_r        <= '0;
      ls_valid_r   <= 1'b0;
      ov_r         <= 1'b0;
      upd_r        <= '0;
      clr_r        <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_ROW_DELAY: row_d_r <= cfg_data;
          CFG_COL_DELAY: col_d_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.clear_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.exec) begin
        if ((op_r == OP_CANCEL) || (is_mem_op && !range_bad && !misal && fwd)) begin
          pv_r[reg_r] <= 1'b0;
        end
        if (enq_ok) begin
          count_r <= count_r + 1'b1;
          seq_r   <= seq_r + 1'b1;
          if (op_r == OP_LOAD) begin
            pv_r[reg_r] <= 1'b1;
          end else begin
            ls_valid_r <= 1'b1;
          end
        end
      end
      if (cmd.serve) begin
        ov_r  <= 1'b1;
        upd_r <= upd_nxt;
        if (!sel_r.is_store) begin
          pv_r[sel_r.rg] <= 1'b0;
        end
      end
      if (cmd.drop_end) begin
        count_r <= count_r - 1'b1;
      end
      if (cmd.push) begin
        hold_valid_r <= 1'b1;
      end else if (cmd.finish) begin
        hold_valid_r <= 1'b0;
      end
      if ((cmd.push && hold_valid_r) || cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r   <= in_operation;
      addr_r <= in_byte_address;
      reg_r  <= PRegW'(in_reg_index);
      val_r  <= in_store_value;
    end
    if (cmd.exec) begin
      res_r <= exec_res;
      if (enq_ok && (op_r == OP_LOAD)) begin
        ptag_r[reg_r]  <= seq_r;
        paddr_r[reg_r] <= addr_r;
      end
      if (enq_ok && (op_r == OP_STORE)) begin
        ls_addr_r <= addr_r;
        ls_val_r  <= val_r;
      end
    end
    if (cmd.drain_latch) begin
      dtag_r <= ptag_r[pidx];
      drow_r <= RowW'(paddr_r[pidx][AddrW-1:ColW+2]);
      dcol_r <= paddr_r[pidx][ColW+1:2];
    end
    if (cmd.scan_start) begin
      scan_r   <= '0;
      rd_vld_r <= 1'b0;
      oh_f_r   <= 1'b0;
      m_f_r    <= 1'b0;
      d_f_r    <= 1'b0;
    end
    if (cmd.scan_step) begin
      rd_vld_r <= scan_r < count_r;
      rd_idx_r <= scan_r[QIdxW-1:0];
      if (scan_r < count_r) begin
        scan_r <= scan_r + 1'b1;
      end
      if (rd_vld_r) begin
        if (ov_r && (scan_e.row == orow_r) && (!oh_f_r || (scan_e.col < oh_col_r))) begin
          oh_f_r   <= 1'b1;
          oh_idx_r <= rd_idx_r;
          oh_col_r <= scan_e.col;
        end
        if (!m_f_r || (scan_e.row < m_row_r) ||
            ((scan_e.row == m_row_r) && (scan_e.col < m_col_r))) begin
          m_f_r   <= 1'b1;
          m_idx_r <= rd_idx_r;
          m_row_r <= scan_e.row;
          m_col_r <= scan_e.col;
        end
        if (!d_f_r && (scan_e.row == drow_r) && (scan_e.col == dcol_r)) begin
          d_f_r   <= 1'b1;
          d_idx_r <= rd_idx_r;
        end
      end
    end
    if (cmd.sel_read) begin
      sel_idx_r <= chosen;
    end
    if (cmd.sel_capture) begin
      sel_r <= entry_t'(q_rdata);
    end
    if (cmd.check) begin
      served_r <= !stale;
      target_r <= is_target;
      comp_r   <= sel_idx_r;
    end
    if (cmd.serve) begin
      lat_r  <= lat_c;
      sw_r   <= sw_c;
      orow_r <= sel_r.row;
    end
    if (cmd.form) begin
      res_r <= served_res;
    end
    if (cmd.drop_wr) begin
      comp_r <= comp_r + 1'b1;
    end
    if (cmd.push) begin
      hold_r <= res_r;
      if (hold_valid_r) begin
        out_res_r  <= hold_r;
        out_last_r <= 1'b0;
      end
    end
    if (cmd.finish) begin
      out_res_r  <= hold_valid_r ? hold_r : idle_res;
      out_last_r <= 1'b1;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.clear_done = clr_r == MemAW'(MemDepth - 1);
    sts.pend_valid = pv_r[pidx];
    sts.scan_done  = (scan_r == count_r) && !rd_vld_r;
    sts.found      = found;
    sts.stale      = stale;
    sts.served     = served_r;
    sts.target     = target_r;
    sts.hold_valid = hold_valid_r;
    sts.out_free   = out_free;
    sts.drop_more  = drop_more;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

`include "dram_row_first_request_scheduler_assert.svh"

  `DRFRS_ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_r <= QCntW'(QueueDepth), "queue count beyond depth")
  `DRFRS_ASSERT_NEXT(a_upd_monotonic, clk, rst_n, rst_n, upd_r >= $past(upd_r), "update count went down")
  `DRFRS_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.push && hold_valid_r, out_free, "result beat overwritten")

endmodule

/* rtl/drfrs_ctrl.sv */
// Controller: sequences enqueue, scan, selection, service and queue compaction.
module drfrs_ctrl import drfrs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (sts.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        case (sts.op)
          OP_LOAD, OP_STORE, OP_CANCEL: state_nxt = S_PUSH;
          OP_DISPATCH: state_nxt = S_SCAN_INIT;
          OP_DRAIN: state_nxt = sts.pend_valid ? S_SCAN_INIT : S_FINISH;
          default: state_nxt = S_FINISH;
        endcase
      end
      S_PUSH: begin
        if (!sts.hold_valid || sts.out_free) state_nxt = S_FINISH;
      end
      S_SPUSH: begin
        if (!sts.hold_valid || sts.out_free) state_nxt = S_DROP_RD;
      end
      S_FINISH: begin
        if (sts.out_free) state_nxt = S_IDLE;
      end
      S_SCAN_INIT: state_nxt = S_SCAN;
      S_SCAN: begin
        if (sts.scan_done) state_nxt = S_SELECT;
      end
      S_SELECT: state_nxt = sts.found ? S_LOAD : S_FINISH;
      S_LOAD: state_nxt = S_CHECK;
      S_CHECK: state_nxt = sts.stale ? S_DROP_RD : S_SERVE;
      S_SERVE: state_nxt = S_FORM;
      S_FORM: state_nxt = S_SPUSH;
      S_DROP_RD: begin
        if (sts.drop_more) begin
          state_nxt = S_DROP_WR;
        end else if (sts.served && ((sts.op == OP_DISPATCH) || sts.target)) begin
          state_nxt = S_FINISH;
        end else begin
          state_nxt = S_SCAN_INIT;
        end
      end
      S_DROP_WR: state_nxt = S_DROP_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        in_ready     = 1'b1;
        cmd.latch_in = in_valid;
      end
      S_DECODE: begin
        case (sts.op)
          OP_LOAD, OP_STORE, OP_CANCEL: cmd.exec = 1'b1;
          OP_DRAIN: cmd.drain_latch = sts.pend_valid;
          default: ;
        endcase
      end
      S_PUSH, S_SPUSH: cmd.push = !sts.hold_valid || sts.out_free;
      S_FINISH: cmd.finish = sts.out_free;
      S_SCAN_INIT: cmd.scan_start = 1'b1;
      S_SCAN: cmd.scan_step = !sts.scan_done;
      S_SELECT: cmd.sel_read = sts.found;
      S_LOAD: cmd.sel_capture = 1'b1;
      S_CHECK: cmd.check = 1'b1;
      S_SERVE: cmd.serve = 1'b1;
      S_FORM: cmd.form = 1'b1;
      S_DROP_RD: begin
        cmd.drop_rd  = sts.drop_more;
        cmd.drop_end = !sts.drop_more;
      end
      S_DROP_WR: cmd.drop_wr = 1'b1;
      default: ;
    endcase
  end

`include "dram_row_first_request_scheduler_assert.svh"

  `DRFRS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_valid && in_ready, state_r == S_DECODE, "accepted beat not decoded")
  `DRFRS_ASSERT_IMPL(a_ready_only_idle, clk, rst_n, in_ready, state_r == S_IDLE, "ready outside idle")
  `DRFRS_ASSERT_IMPL(a_one_push, clk, rst_n, cmd.push, !cmd.finish, "push and finish together")

endmodule
